// ----- rtl/qpps_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and helpers for the quadrature pd position servo
// no dependencies; used by the interfaces, controller, datapath and top level
package qpps_pkg;

  // default fraction bits of the filtered velocity
  localparam int VEL_FRAC_BITS_DEF = 16;

  // datapath widths
  localparam int POS_W   = 32;
  localparam int VF_W    = 48;
  localparam int VF_LO_W = 24;
  localparam int ERR_W   = 34;
  localparam int MA_W    = 35;
  localparam int MB_W    = 18;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = 66;
  localparam int DRV_W   = 9;
  localparam int FILT_SHIFT = 16;
  localparam int RND_SHIFT  = 8;

  // filter coefficients, 0.8 and 0.2 in Q.16
  localparam logic signed [MB_W-1:0] FILT_KEEP = 18'sd52429;
  localparam logic signed [MB_W-1:0] FILT_NEW  = 18'sd13107;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP       = 3'd0,
    CFG_KD       = 3'd1,
    CFG_DRV_MAX  = 3'd2,
    CFG_DRV_MIN  = 3'd3,
    CFG_STOP     = 3'd4,
    CFG_BACKLASH = 3'd5
  } cfg_idx_t;

  // request codes of an input beat
  typedef enum logic [1:0] {
    REQ_ENC    = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_TARGET = 2'd2,
    REQ_ZERO   = 2'd3
  } req_t;

  // multiply/accumulate steps of a control tick
  typedef enum logic [2:0] {
    STEP_VF_LO = 3'd0,
    STEP_VF_HI = 3'd1,
    STEP_DELTA = 3'd2,
    STEP_KD_LO = 3'd3,
    STEP_KD_HI = 3'd4,
    STEP_KP    = 3'd5
  } step_t;

  // controller to datapath commands
  typedef struct packed {
    logic  take;
    logic  load;
    logic  mul;
    logic  acc;
    logic  absv;
    logic  fin;
    step_t step;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic goal_valid;
  } status_t;

  // x4 quadrature step from {previous pins, current pins}
  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = 2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = -2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/qpps_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces for request beats and result beats
// depends on qpps_pkg for field widths
interface qpps_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        req_type;
  logic [1:0]                        enc_ab;
  logic signed [qpps_pkg::POS_W-1:0] target_pos;

  modport source (output valid, req_type, enc_ab, target_pos, input ready);
  modport sink (input valid, req_type, enc_ab, target_pos, output ready);
endinterface

interface qpps_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [qpps_pkg::POS_W-1:0] position;
  logic signed [qpps_pkg::DRV_W-1:0] drive;
  logic                              dir_fwd;
  logic                              dir_rev;
  logic [7:0]                        duty;
  logic                              at_target;
  logic                              target_valid;

  modport source (output valid, position, drive, dir_fwd, dir_rev, duty, at_target,
                  target_valid, input ready);
  modport sink (input valid, position, drive, dir_fwd, dir_rev, duty, at_target,
                target_valid, output ready);
endinterface

// ----- rtl/quadrature_pd_position_servo.sv -----
`timescale 1ns / 1ps
// encoder, set target, zero and ticks without a target: result registered at accept,
// one beat per cycle while results are taken
// tick with a target: result after six passes of the shared 35x18 multiplier
// (multiply then accumulate) plus magnitude and rounding stages
// reset clears position, filter and loop state and loads register defaults at once
module quadrature_pd_position_servo #(
  parameter int VEL_FRAC_BITS = qpps_pkg::VEL_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [qpps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qpps_pkg::CFG_DAT_W-1:0]  cfg_data,
  qpps_req_if.sink                        item,
  qpps_rsp_if.source                      result
);

  qpps_pkg::cmd_t    cmd;
  qpps_pkg::status_t status;
  logic [qpps_pkg::DRV_W-1:0] drive_mag;

  // sequencing and handshake
  qpps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_req    (item.req_type),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and state
  qpps_dpath #(
    .VEL_FRAC_BITS (VEL_FRAC_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_req           (item.req_type),
    .in_enc_ab        (item.enc_ab),
    .in_target_pos    (item.target_pos),
    .cmd              (cmd),
    .status           (status),
    .out_position     (result.position),
    .out_drive        (result.drive),
    .out_at_target    (result.at_target),
    .out_target_valid (result.target_valid)
  );

  // bridge direction and duty from the registered drive
  assign drive_mag      = result.drive[qpps_pkg::DRV_W-1] ? -result.drive : result.drive;
  assign result.duty    = drive_mag[7:0];
  assign result.dir_fwd = !result.drive[qpps_pkg::DRV_W-1] && (result.drive != '0);
  assign result.dir_rev = result.drive[qpps_pkg::DRV_W-1];

endmodule

// ----- rtl/qpps_ctrl.sv -----
`timescale 1ns / 1ps
// servo controller: handshake, tick sequencing and result valid
// depends on qpps_pkg for command/status structs and codes
module qpps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_req,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  qpps_pkg::status_t   status,
  output qpps_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ACC  = 5'b00100,
    S_ABS  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t              state, state_next;
  qpps_pkg::step_t     step, step_next;
  logic                out_valid_next;
  logic                slot_free, take, long_tick, fin;

  // handshake decode
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && slot_free;
  assign take      = in_valid && in_ready;
  assign long_tick = take && (qpps_pkg::req_t'(in_req) == qpps_pkg::REQ_TICK) &&
                     status.goal_valid;
  assign fin       = (state == S_FIN) && slot_free;

  // commands to the datapath
  always_comb begin
    cmd.take = take;
    cmd.load = (take && !long_tick) || fin;
    cmd.mul  = (state == S_MUL);
    cmd.acc  = (state == S_ACC);
    cmd.absv = (state == S_ABS);
    cmd.fin  = fin;
    cmd.step = step;
  end

  // sequencer
  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      S_IDLE: begin
        if (long_tick) begin
          state_next = S_MUL;
          step_next  = qpps_pkg::STEP_VF_LO;
        end
      end
      S_MUL: state_next = S_ACC;
      S_ACC: begin
        if (step == qpps_pkg::STEP_KP) begin
          state_next = S_ABS;
        end else begin
          state_next = S_MUL;
          step_next  = qpps_pkg::step_t'(step + 3'd1);
        end
      end
      S_ABS: state_next = S_FIN;
      S_FIN: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // result valid
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= qpps_pkg::STEP_VF_LO;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  // checks
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL || state == S_ACC) |-> (step <= qpps_pkg::STEP_KP))
    else $error("tick step out of range");

  a_abs_to_fin: assert property (@(posedge clk) disable iff (rst)
    (state == S_ABS) |=> (state == S_FIN))
    else $error("rounding did not follow magnitude stage");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("result loaded without valid");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && !out_ready) |=> (state == S_FIN))
    else $error("tick finished while result slot busy");

endmodule

// ----- rtl/qpps_dpath.sv -----
`timescale 1ns / 1ps
// servo datapath: config registers, position counter, velocity filter, pd drive
// depends on qpps_pkg; steered by qpps_ctrl through cmd_t
module qpps_dpath #(
  parameter int VEL_FRAC_BITS = qpps_pkg::VEL_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [qpps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [qpps_pkg::CFG_DAT_W-1:0]         cfg_data,
  input  logic [1:0]                             in_req,
  input  logic [1:0]                             in_enc_ab,
  input  logic signed [qpps_pkg::POS_W-1:0]      in_target_pos,
  input  qpps_pkg::cmd_t                         cmd,
  output qpps_pkg::status_t                      status,
  output logic signed [qpps_pkg::POS_W-1:0]      out_position,
  output logic signed [qpps_pkg::DRV_W-1:0]      out_drive,
  output logic                                   out_at_target,
  output logic                                   out_target_valid
);

  localparam int POS_W  = qpps_pkg::POS_W;
  localparam int VF_W   = qpps_pkg::VF_W;
  localparam int LO_W   = qpps_pkg::VF_LO_W;
  localparam int ERR_W  = qpps_pkg::ERR_W;
  localparam int MA_W   = qpps_pkg::MA_W;
  localparam int MB_W   = qpps_pkg::MB_W;
  localparam int PROD_W = qpps_pkg::PROD_W;
  localparam int ACC_W  = qpps_pkg::ACC_W;
  localparam int DRV_W  = qpps_pkg::DRV_W;
  localparam int RND_W  = ACC_W - qpps_pkg::RND_SHIFT;
  // velocity clamp so the filter state stays within its width
  localparam logic signed [63:0] DELTA_LIM = (64'sd1 <<< (47 - VEL_FRAC_BITS)) - 64'sd1;

  // configuration
  logic [15:0]       kp_gain, kd_gain, stop_band;
  logic [7:0]        drive_max, drive_min;
  logic signed [7:0] backlash_offset;

  // servo state
  logic [POS_W-1:0]         pos_count, pos_next;
  logic [1:0]               prev_pins, prev_next;
  logic                     pins_seeded, seeded_next;
  logic [POS_W-1:0]         last_tick_pos, last_next;
  logic signed [VF_W-1:0]   vel_filtered;
  logic [POS_W-1:0]         goal_pos, goal_next;
  logic                     goal_valid, gv_next;
  logic signed [DRV_W-1:0]  drive_now, drive_next;
  logic                     settled, settled_next;

  // tick working registers
  logic signed [POS_W-1:0]  delta_r;
  logic signed [ERR_W-1:0]  err_r;
  logic                     band;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]         absu;
  logic                     neg;

  // combinational helpers
  logic signed [1:0]        qstep;
  logic signed [63:0]       d64;
  logic signed [POS_W-1:0]  delta_c;
  logic signed [ERR_W-1:0]  err_raw, err_c;
  logic [ERR_W-1:0]         err_abs;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [ACC_W-1:0]  filt_sum;
  logic [ACC_W-1:0]         rnd_sum;
  logic [RND_W-1:0]         rnd;
  logic [7:0]               mag;
  logic signed [DRV_W-1:0]  fin_drive;

  assign status.goal_valid = goal_valid;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain         <= 16'd90;
      kd_gain         <= 16'd0;
      drive_max       <= 8'd200;
      drive_min       <= 8'd35;
      stop_band       <= 16'd5;
      backlash_offset <= -8'sd5;
    end else if (cfg_we) begin
      case (qpps_pkg::cfg_idx_t'(cfg_index))
        qpps_pkg::CFG_KP:       kp_gain         <= cfg_data;
        qpps_pkg::CFG_KD:       kd_gain         <= cfg_data;
        qpps_pkg::CFG_DRV_MAX:  drive_max       <= cfg_data[7:0];
        qpps_pkg::CFG_DRV_MIN:  drive_min       <= cfg_data[7:0];
        qpps_pkg::CFG_STOP:     stop_band       <= cfg_data;
        qpps_pkg::CFG_BACKLASH: backlash_offset <= signed'(cfg_data[7:0]);
        default: ;
      endcase
    end
  end

  // velocity since last tick, clamped
  always_comb begin
    d64 = 64'(signed'(pos_count - last_tick_pos));
    if (d64 > DELTA_LIM) delta_c = DELTA_LIM[POS_W-1:0];
    else if (d64 < -DELTA_LIM) delta_c = -DELTA_LIM[POS_W-1:0];
    else delta_c = d64[POS_W-1:0];
  end

  // position error with backlash compensation
  always_comb begin
    err_raw = ERR_W'(signed'(goal_pos)) - ERR_W'(signed'(pos_count));
    err_c   = err_raw;
    if (err_raw < 0) err_c = err_raw - ERR_W'(backlash_offset);
  end

  // next state for a request beat or the end of a tick
  always_comb begin
    qstep        = qpps_pkg::quad_step({prev_pins, in_enc_ab});
    pos_next     = pos_count;
    prev_next    = prev_pins;
    seeded_next  = pins_seeded;
    last_next    = last_tick_pos;
    goal_next    = goal_pos;
    gv_next      = goal_valid;
    drive_next   = drive_now;
    settled_next = settled;
    if (cmd.fin) begin
      drive_next   = fin_drive;
      settled_next = band;
    end else begin
      case (qpps_pkg::req_t'(in_req))
        qpps_pkg::REQ_ENC: begin
          if (pins_seeded) pos_next = pos_count + POS_W'(qstep);
          seeded_next = 1'b1;
          prev_next   = in_enc_ab;
        end
        qpps_pkg::REQ_TICK: begin
          last_next = pos_count;
          if (!goal_valid) begin
            drive_next   = '0;
            settled_next = 1'b0;
          end
        end
        qpps_pkg::REQ_TARGET: begin
          goal_next = in_target_pos;
          gv_next   = 1'b1;
        end
        qpps_pkg::REQ_ZERO: begin
          pos_next     = '0;
          goal_next    = '0;
          gv_next      = 1'b0;
          drive_next   = '0;
          settled_next = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // servo state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_count     <= '0;
      prev_pins     <= '0;
      pins_seeded   <= 1'b0;
      last_tick_pos <= '0;
      goal_pos      <= '0;
      goal_valid    <= 1'b0;
      drive_now     <= '0;
      settled       <= 1'b0;
    end else if (cmd.take || cmd.fin) begin
      pos_count     <= pos_next;
      prev_pins     <= prev_next;
      pins_seeded   <= seeded_next;
      last_tick_pos <= last_next;
      goal_pos      <= goal_next;
      goal_valid    <= gv_next;
      drive_now     <= drive_next;
      settled       <= settled_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_position     <= pos_next;
      out_drive        <= drive_next;
      out_at_target    <= settled_next;
      out_target_valid <= gv_next;
    end
  end

  // tick operands captured at accept, stop band check while the tick runs
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      delta_r <= delta_c;
      err_r   <= err_c;
    end
    band    <= (err_abs <= ERR_W'(stop_band));
  end

  // stop band magnitude
  always_comb err_abs = err_r[ERR_W-1] ? ERR_W'(-err_r) : ERR_W'(err_r);

  // shared multiplier operand select
  always_comb begin
    case (cmd.step)
      qpps_pkg::STEP_VF_LO: begin
        mul_a = {{(MA_W-LO_W){1'b0}}, vel_filtered[LO_W-1:0]};
        mul_b = qpps_pkg::FILT_KEEP;
      end
      qpps_pkg::STEP_VF_HI: begin
        mul_a = MA_W'(signed'(vel_filtered[VF_W-1:LO_W]));
        mul_b = qpps_pkg::FILT_KEEP;
      end
      qpps_pkg::STEP_DELTA: begin
        mul_a = MA_W'(delta_r);
        mul_b = qpps_pkg::FILT_NEW;
      end
      qpps_pkg::STEP_KD_LO: begin
        mul_a = {{(MA_W-LO_W){1'b0}}, vel_filtered[LO_W-1:0]};
        mul_b = signed'({2'b00, kd_gain});
      end
      qpps_pkg::STEP_KD_HI: begin
        mul_a = MA_W'(signed'(vel_filtered[VF_W-1:LO_W]));
        mul_b = signed'({2'b00, kd_gain});
      end
      qpps_pkg::STEP_KP: begin
        mul_a = MA_W'(err_r);
        mul_b = signed'({2'b00, kp_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign filt_sum = acc + (ACC_W'(prod) <<< VEL_FRAC_BITS);

  // multiply and accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      vel_filtered <= '0;
    end else if (cmd.acc && cmd.step == qpps_pkg::STEP_DELTA) begin
      vel_filtered <= filt_sum[qpps_pkg::FILT_SHIFT +: VF_W];
    end
    if (cmd.mul) prod <= mul_a * mul_b;
    if (cmd.acc) begin
      case (cmd.step)
        qpps_pkg::STEP_VF_LO, qpps_pkg::STEP_KD_LO: acc <= ACC_W'(prod);
        qpps_pkg::STEP_VF_HI, qpps_pkg::STEP_KD_HI:
          acc <= acc + (ACC_W'(prod) <<< LO_W);
        qpps_pkg::STEP_DELTA: acc <= filt_sum;
        qpps_pkg::STEP_KP: acc <= ACC_W'(prod) - (acc >>> VEL_FRAC_BITS);
        default: acc <= acc;
      endcase
    end
    if (cmd.absv) begin
      neg  <= acc[ACC_W-1];
      absu <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    end
  end

  // round half away from zero, clamp, raise to minimum, zero inside the stop band
  always_comb begin
    rnd_sum = absu + ACC_W'(128);
    rnd     = rnd_sum[ACC_W-1:qpps_pkg::RND_SHIFT];
    if (rnd > RND_W'(drive_max)) mag = drive_max;
    else mag = rnd[7:0];
    if (mag != 8'd0 && mag < drive_min) mag = drive_min;
    if (band) fin_drive = '0;
    else if (neg) fin_drive = DRV_W'(0) - DRV_W'({1'b0, mag});
    else fin_drive = DRV_W'({1'b0, mag});
  end

endmodule
